### design/kfe_pkg.sv
// ----------------------------------------------------------------------------
// kfe_pkg: shared types and constants of the KISS frame encoder
// Holds the transaction payload types, the KISS framing codes and the
// CRC-16/CCITT-FALSE byte update.
// ----------------------------------------------------------------------------
package kfe_pkg;

    localparam logic [7:0]  KISS_FEND  = 8'hC0;
    localparam logic [7:0]  KISS_FESC  = 8'hDB;
    localparam logic [7:0]  KISS_TFEND = 8'hDC;
    localparam logic [7:0]  KISS_TFESC = 8'hDD;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    // One classified payload byte as handed from the front to the back.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first;
        logic        last;
        logic [15:0] crc;
    } queue_entry_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### design/kiss_frame_encoder_crc16_unit.sv
// ----------------------------------------------------------------------------
// kiss_frame_encoder_crc16_unit: KISS framer with CRC-16/CCITT-FALSE trailer
// Top level: front classifier, entry queue and output sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (push/full/data): one payload byte per transaction, with
//   in_last set on the final byte of a frame. Every frame has at least one byte.
//   Result channel (empty/pop/result): the framed stream, one byte per
//   transaction; out_last marks the closing FEND of each frame.
//   An item passes through the queue and then the output register on its
//   way to the result port. Throughput: the output sequencer emits one byte
//   per cycle while the receiver does not stall. A payload byte gives one
//   output byte, or two when it is escaped. The first byte of a frame adds
//   the opening FEND; the last adds the escaped CRC bytes and the closing
//   FEND. The sequencer sets this rate.
//   Reset clears the frame state, the CRC, the queue and the output valid flag;
//   the result channel shows empty until the next accepted byte.
//   When the receiver stalls, the waiting result holds, the sequencer stops,
//   the queue of QUEUE_DEPTH entries fills, and full rises.
// ----------------------------------------------------------------------------
module kiss_frame_encoder_crc16_unit
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  kfe_pkg::in_item_t  data,
    output logic               empty,
    input  logic               pop,
    output kfe_pkg::out_item_t result
);

    logic                  q_push;
    logic                  q_pop;
    logic                  q_full;
    logic                  q_empty;
    kfe_pkg::queue_entry_t q_entry;
    kfe_pkg::queue_entry_t q_head;

    assign full = q_full;

    kfe_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .data    (data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    kfe_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_entry (q_entry),
        .rd_en    (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    kfe_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

### design/kfe_front.sv
// ----------------------------------------------------------------------------
// kfe_front: input side of the KISS frame encoder
// Accepts payload bytes, tracks frame boundaries and the running CRC, and
// writes one classified entry per byte into the queue.
// ----------------------------------------------------------------------------
module kfe_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  kfe_pkg::in_item_t     data,
    input  logic                  q_full,
    output logic                  q_push,
    output kfe_pkg::queue_entry_t q_entry
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        inside_reg;
    logic        inside_next;
    logic [15:0] crc_start;

    assign q_push    = push && !q_full;
    // A frame's first byte starts from the initial value, not the stored CRC.
    assign crc_start = inside_reg ? crc_reg : kfe_pkg::CRC_INIT;

    always_comb
    begin
        q_entry.data_byte = data.in_byte;
        q_entry.first     = !inside_reg;
        q_entry.last      = data.in_last;
        q_entry.crc       = kfe_pkg::crc_feed(crc_start, data.in_byte);
        crc_next          = crc_reg;
        inside_next       = inside_reg;
        if (q_push)
        begin
            crc_next    = q_entry.crc;
            inside_next = !data.in_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg    <= kfe_pkg::CRC_INIT;
            inside_reg <= 1'b0;
        end
        else
        begin
            crc_reg    <= crc_next;
            inside_reg <= inside_next;
        end
    end

endmodule

### design/kfe_queue.sv
// ----------------------------------------------------------------------------
// kfe_queue: short queue between the front and back of the encoder
// A small register FIFO; the head entry is visible while not empty.
// ----------------------------------------------------------------------------
module kfe_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  kfe_pkg::queue_entry_t wr_entry,
    input  logic                  rd_en,
    output kfe_pkg::queue_entry_t head,
    output logic                  full,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    kfe_pkg::queue_entry_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/kfe_back.sv
// ----------------------------------------------------------------------------
// kfe_back: output side of the KISS frame encoder
// Walks the head queue entry through opening FEND (first byte only), escaped
// payload byte, escaped CRC bytes and closing FEND (last byte only), one output
// byte per cycle while the output register is free or drained, into a register.
// ----------------------------------------------------------------------------
module kfe_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  kfe_pkg::queue_entry_t head,
    input  logic                  q_empty,
    output logic                  q_pop,
    input  logic                  pop,
    output logic                  empty,
    output kfe_pkg::out_item_t    result
);

    typedef enum logic [3:0] {
        ST_START = 4'b0001,
        ST_DATA  = 4'b0010,
        ST_ESC   = 4'b0100,
        ST_CLOSE = 4'b1000
    } back_state_t;

    typedef enum logic [1:0] {
        SEL_DATA   = 2'd0,
        SEL_CRC_LO = 2'd1,
        SEL_CRC_HI = 2'd2
    } value_sel_t;

    back_state_t        state_reg;
    back_state_t        state_next;
    value_sel_t         sel_reg;
    value_sel_t         sel_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    kfe_pkg::out_item_t out_reg;
    kfe_pkg::out_item_t out_next;

    logic       advance;
    logic       fire;
    logic       value_done;
    logic [7:0] cur_value;
    logic       needs_esc;
    logic [7:0] esc_code;
    logic [7:0] emit_byte;
    logic       emit_last;

    assign empty   = !out_valid_reg;
    assign result  = out_reg;
    // The output register takes a new byte whenever it is free or being drained.
    assign advance = !out_valid_reg || pop;
    assign fire    = advance && !q_empty;

    always_comb
    begin
        case (sel_reg)
            SEL_DATA:   cur_value = head.data_byte;
            SEL_CRC_LO: cur_value = head.crc[7:0];
            SEL_CRC_HI: cur_value = head.crc[15:8];
            default:    cur_value = head.data_byte;
        endcase
    end

    assign needs_esc = (cur_value == kfe_pkg::KISS_FEND) || (cur_value == kfe_pkg::KISS_FESC);
    assign esc_code  = (cur_value == kfe_pkg::KISS_FEND) ? kfe_pkg::KISS_TFEND
                                                          : kfe_pkg::KISS_TFESC;

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        q_pop      = 1'b0;
        value_done = 1'b0;
        emit_byte  = cur_value;
        emit_last  = 1'b0;
        if (fire)
        begin
            case (state_reg)
                ST_START:
                begin
                    if (head.first)
                    begin
                        emit_byte  = kfe_pkg::KISS_FEND;
                        state_next = ST_DATA;
                    end
                    else if (needs_esc)
                    begin
                        emit_byte  = kfe_pkg::KISS_FESC;
                        state_next = ST_ESC;
                    end
                    else
                    begin
                        value_done = 1'b1;
                    end
                end
                ST_DATA:
                begin
                    if (needs_esc)
                    begin
                        emit_byte  = kfe_pkg::KISS_FESC;
                        state_next = ST_ESC;
                    end
                    else
                    begin
                        value_done = 1'b1;
                    end
                end
                ST_ESC:
                begin
                    emit_byte  = esc_code;
                    value_done = 1'b1;
                end
                ST_CLOSE:
                begin
                    emit_byte  = kfe_pkg::KISS_FEND;
                    emit_last  = 1'b1;
                    q_pop      = 1'b1;
                    state_next = ST_START;
                    sel_next   = SEL_DATA;
                end
                default:
                begin
                    state_next = ST_START;
                    sel_next   = SEL_DATA;
                end
            endcase

            if (value_done)
            begin
                case (sel_reg)
                    SEL_DATA:
                    begin
                        if (head.last)
                        begin
                            sel_next   = SEL_CRC_LO;
                            state_next = ST_DATA;
                        end
                        else
                        begin
                            q_pop      = 1'b1;
                            state_next = ST_START;
                        end
                    end
                    SEL_CRC_LO:
                    begin
                        sel_next   = SEL_CRC_HI;
                        state_next = ST_DATA;
                    end
                    SEL_CRC_HI:
                    begin
                        state_next = ST_CLOSE;
                    end
                    default:
                    begin
                        sel_next   = SEL_DATA;
                        state_next = ST_START;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance)
        begin
            out_valid_next    = fire;
            out_next.out_byte = emit_byte;
            out_next.out_last = emit_last;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_START;
            sel_reg       <= SEL_DATA;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### design/kfe_checker.sv
// ----------------------------------------------------------------------------
// kfe_checker: port-level checks of the KISS frame encoder
// Watches the result channel for framing order and stall behavior.
// ----------------------------------------------------------------------------
module kfe_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input kfe_pkg::out_item_t result
);

    // Set while the next result must be the opening FEND of a frame.
    logic expect_open_reg;
    logic expect_open_next;

    always_comb
    begin
        expect_open_next = expect_open_reg;
        if (pop && !empty)
        begin
            expect_open_next = result.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_open_reg <= 1'b1;
        end
        else
        begin
            expect_open_reg <= expect_open_next;
        end
    end

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed while stalled");

    a_last_is_fend: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.out_last) |-> (result.out_byte == kfe_pkg::KISS_FEND))
        else $error("frame closed with a byte other than FEND");

    a_frame_opens: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && expect_open_reg) |->
            (result.out_byte == kfe_pkg::KISS_FEND && !result.out_last))
        else $error("frame did not start with an opening FEND");

    a_no_inner_fend: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !expect_open_reg && result.out_byte == kfe_pkg::KISS_FEND)
            |-> result.out_last)
        else $error("unescaped FEND inside a frame");

endmodule

bind kiss_frame_encoder_crc16_unit kfe_checker u_kfe_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the KISS frame encoder with CRC-16 trailer
// Sends payload bytes grouped into frames, first a directed set and then
// random frames. A built-in encoder predicts the framed and escaped byte
// stream, and every popped result is compared with it. The sender works in
// bursts and the receiver stalls, including one long hold-off that fills
// the block.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int ITEM_TARGET   = 280;
    localparam int TIMEOUT_UNITS = 400000;
    localparam int DRAIN_CYCLES  = 12;

    logic               clk   = 1'b0;
    logic               rst_n = 1'b0;
    logic               push  = 1'b0;
    logic               pop   = 1'b0;
    logic               full;
    logic               empty;
    kfe_pkg::in_item_t  data  = '0;
    kfe_pkg::out_item_t result;

    kiss_frame_encoder_crc16_unit dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .data   (data),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always #1 clk = ~clk;

    // Encoder state kept by the bench.
    logic [15:0]        frame_crc = kfe_pkg::CRC_INIT;
    logic               in_frame  = 1'b0;
    kfe_pkg::out_item_t expected_stream[$];
    kfe_pkg::in_item_t  pending_items[$];

    int   error_count    = 0;
    int   accepted_count = 0;
    logic byte_taken     = 1'b0;
    logic rx_hold        = 1'b0;

    int   burst_left = 1;
    int   gap_left   = 0;
    int   rx_mode    = 0;
    int   rx_mode_left = 0;
    int   rx_cycle   = 0;
    logic rx_next;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 7; k >= 0; k--)
        begin
            fb = c[15] ^ b[k];
            c  = {c[14:0], 1'b0};
            if (fb)
            begin
                c = c ^ kfe_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic void emit_escaped(input logic [7:0] b);
        kfe_pkg::out_item_t o;
        o.out_last = 1'b0;
        if (b == kfe_pkg::KISS_FEND || b == kfe_pkg::KISS_FESC)
        begin
            o.out_byte = kfe_pkg::KISS_FESC;
            expected_stream.push_back(o);
            o.out_byte = (b == kfe_pkg::KISS_FEND) ? kfe_pkg::KISS_TFEND
                                                   : kfe_pkg::KISS_TFESC;
            expected_stream.push_back(o);
        end
        else
        begin
            o.out_byte = b;
            expected_stream.push_back(o);
        end
    endfunction

    // Appends the output bytes that one accepted payload byte produces.
    function automatic void frame_encode(input kfe_pkg::in_item_t it);
        kfe_pkg::out_item_t o;
        if (!in_frame)
        begin
            o.out_byte = kfe_pkg::KISS_FEND;
            o.out_last = 1'b0;
            expected_stream.push_back(o);
            in_frame  = 1'b1;
            frame_crc = kfe_pkg::CRC_INIT;
        end
        emit_escaped(it.in_byte);
        frame_crc = crc16_byte(frame_crc, it.in_byte);
        if (it.in_last)
        begin
            emit_escaped(frame_crc[7:0]);
            emit_escaped(frame_crc[15:8]);
            o.out_byte = kfe_pkg::KISS_FEND;
            o.out_last = 1'b1;
            expected_stream.push_back(o);
            frame_crc = kfe_pkg::CRC_INIT;
            in_frame  = 1'b0;
        end
    endfunction

    task automatic queue_byte(input logic [7:0] b, input logic last);
        kfe_pkg::in_item_t it;
        it.in_byte = b;
        it.in_last = last;
        pending_items.push_back(it);
    endtask

    // Queues a three-byte frame whose trailing two bytes steer the CRC to
    // the requested value, so that escaped CRC bytes get exercised.
    task automatic queue_crc_frame(input logic [7:0] head, input logic [15:0] target);
        logic [15:0] start;
        logic [15:0] tail;
        start = crc16_byte(kfe_pkg::CRC_INIT, head);
        tail  = '0;
        for (int v = 0; v < 65536; v++)
        begin
            if (crc16_byte(crc16_byte(start, v[15:8]), v[7:0]) == target)
            begin
                tail = v[15:0];
                break;
            end
        end
        queue_byte(head, 1'b0);
        queue_byte(tail[15:8], 1'b0);
        queue_byte(tail[7:0], 1'b1);
    endtask

    function automatic logic [7:0] random_payload();
        logic [7:0] b;
        case ($urandom_range(0, 7))
            0:       b = kfe_pkg::KISS_FEND;
            1:       b = kfe_pkg::KISS_FESC;
            2:       b = ($urandom_range(0, 1) != 0) ? kfe_pkg::KISS_TFEND
                                                     : kfe_pkg::KISS_TFESC;
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    function automatic logic [7:0] random_crc_part();
        logic [7:0] b;
        case ($urandom_range(0, 2))
            0:       b = kfe_pkg::KISS_FEND;
            1:       b = kfe_pkg::KISS_FESC;
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    // Stimulus
    initial
    begin
        int frame_len;

        // Single-byte frames at the extremes and on both escape codes.
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);
        queue_byte(kfe_pkg::KISS_FEND, 1'b1);
        queue_byte(kfe_pkg::KISS_FESC, 1'b1);
        // A longer frame mixing escaped bytes and their look-alikes.
        queue_byte(kfe_pkg::KISS_FEND, 1'b0);
        queue_byte(kfe_pkg::KISS_FESC, 1'b0);
        queue_byte(kfe_pkg::KISS_TFEND, 1'b0);
        queue_byte(kfe_pkg::KISS_TFESC, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h55, 1'b0);
        queue_byte(8'hAA, 1'b1);
        // Frames whose CRC bytes themselves need escaping.
        queue_crc_frame(kfe_pkg::KISS_FEND, {kfe_pkg::KISS_FESC, kfe_pkg::KISS_FEND});
        queue_crc_frame(kfe_pkg::KISS_FESC, {kfe_pkg::KISS_FEND, kfe_pkg::KISS_FESC});
        queue_crc_frame(8'h01, {kfe_pkg::KISS_FEND, kfe_pkg::KISS_FEND});
        queue_crc_frame(8'hFE, {kfe_pkg::KISS_FESC, kfe_pkg::KISS_FESC});

        while (pending_items.size() < ITEM_TARGET)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                queue_crc_frame(random_payload(), {random_crc_part(), random_crc_part()});
            end
            else
            begin
                frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30)
                                                          : $urandom_range(1, 6);
                for (int i = 0; i < frame_len; i++)
                begin
                    queue_byte(random_payload(), (i == frame_len - 1));
                end
            end
        end

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || push)
        begin
            @(posedge clk);
        end
        while (expected_stream.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("[kiss_frame_encoder_crc16_unit] OK");
        end
        else
        begin
            $display("[kiss_frame_encoder_crc16_unit] ERROR");
        end
        $finish;
    end

    initial
    begin
        #(TIMEOUT_UNITS);
        $display("[kiss_frame_encoder_crc16_unit] ERROR");
        $finish;
    end

    // Holds the receiver off long enough for the input side to back up.
    initial
    begin
        while (accepted_count < 120)
        begin
            @(negedge clk);
        end
        rx_hold <= 1'b1;
        repeat (80) @(negedge clk);
        rx_hold <= 1'b0;
    end

    // Sender: bursts of transactions separated by random gaps.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (push && byte_taken)
            begin
                void'(pending_items.pop_front());
            end
            if (!push || byte_taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    push <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    push <= 1'b1;
                    data <= pending_items[0];
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Receiver: switches between several stall patterns.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rx_cycle++;
            if (rx_mode_left == 0)
            begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(32, 96);
            end
            else
            begin
                rx_mode_left--;
            end
            case (rx_mode)
                0:       rx_next = 1'b1;
                1:       rx_next = ($urandom_range(0, 1) != 0);
                2:       rx_next = ($urandom_range(0, 3) == 0);
                default: rx_next = (rx_cycle % 8 != 0);
            endcase
            pop <= rx_next && !rx_hold;
        end
    end

    // Monitor: records accepted inputs and checks every popped result.
    always @(posedge clk)
    begin
        kfe_pkg::out_item_t want;
        if (rst_n)
        begin
            byte_taken = push && !full;
            if (byte_taken)
            begin
                frame_encode(data);
                accepted_count++;
            end
            if (pop && !empty)
            begin
                if (expected_stream.size() == 0)
                begin
                    $display("%0t: unexpected result byte=%02h last=%0b",
                             $time, result.out_byte, result.out_last);
                    error_count++;
                end
                else
                begin
                    want = expected_stream.pop_front();
                    if (result.out_byte !== want.out_byte)
                    begin
                        $display("%0t: out_byte mismatch expected %02h actual %02h",
                                 $time, want.out_byte, result.out_byte);
                        error_count++;
                    end
                    if (result.out_last !== want.out_last)
                    begin
                        $display("%0t: out_last mismatch expected %0b actual %0b",
                                 $time, want.out_last, result.out_last);
                        error_count++;
                    end
                end
            end
        end
    end

endmodule

### kiss_frame_encoder_crc16_unit.f
design/kfe_pkg.sv
design/kfe_front.sv
design/kfe_queue.sv
design/kfe_back.sv
design/kiss_frame_encoder_crc16_unit.sv
design/kfe_checker.sv
tb/sv/tb_top.sv
